// ----- rtl/core/plcm_pkg.sv -----
`timescale 1ns / 1ps

package plcm_pkg;

    // Default table depth.
    localparam int DEF_MAX_POINTS = 16;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int SLOT_W   = 4;
    localparam int NP_W     = 5;
    localparam int STAT_W   = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // Reset value of the breakpoint count.
    localparam logic [NP_W-1:0] NP_RESET = 5'd2;

    // Request kinds carried in the input tuser.
    localparam logic REQ_MAP   = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Result status codes carried in the output tuser.
    localparam logic [STAT_W-1:0] STAT_INTERP  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LOW     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_HIGH    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_WRITTEN = 2'd3;

endpackage

// ----- rtl/core/piecewise_linear_curve_map.sv -----
`timescale 1ns / 1ps
// A breakpoint write goes straight to the finishing state; a clamped map item reads
// the first and last breakpoints; an interpolated one then scans one segment per
// cycle and on a hit multiplies, then unless the width is zero normalises, runs the
// 16-step shift-subtract divider and sums. One item is taken at a time.
// Reset: rst_n is asynchronous, active low; it clears control state and sets the
// breakpoint count to 2. The breakpoint table is not cleared.

module piecewise_linear_curve_map #(
    parameter int MAX_POINTS = plcm_pkg::DEF_MAX_POINTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Breakpoint count register.
    input  logic                              cfg_we,
    input  logic [plcm_pkg::NP_W-1:0]         cfg_wdata,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: sample[15:0], point_index[19:16], point_in[35:20], point_out[51:36]
    input  logic [plcm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: req_type[0]
    input  logic                              s_axis_tuser,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: mapped[15:0]
    output logic [plcm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [plcm_pkg::STAT_W-1:0]       m_axis_tuser
);

    import plcm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = (IDX_W + 1 > NP_W) ? IDX_W + 1 : NP_W;
    localparam int DIV_STEPS = 16;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    typedef struct packed {
        logic signed [15:0] out;
        logic [15:0]        in;
    } knot_t;

    // Input fields.
    logic        [15:0]       in_sample;
    logic        [SLOT_W-1:0] in_slot;
    logic        [15:0]       in_point_in;
    logic signed [15:0]       in_point_out;

    assign in_sample    = s_axis_tdata[15:0];
    assign in_slot      = s_axis_tdata[19:16];
    assign in_point_in  = s_axis_tdata[35:20];
    assign in_point_out = s_axis_tdata[51:36];

    // Breakpoint table and its registered read port.
    knot_t             knot_mem [MAX_POINTS];
    knot_t             rdata_reg;
    logic [IDX_W-1:0]  rd_addr;

    // Control registers.
    logic [3:0]         state_reg, state_next;
    logic [NP_W-1:0]    num_points_reg, num_points_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic               neg_reg, neg_next;
    logic [16:0]        mag_reg, mag_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [15:0]        px_reg, px_next;
    logic signed [15:0] po_reg, po_next;
    logic signed [15:0] lo_reg, lo_next;
    logic [16:0]        dx_reg, dx_next;
    logic [15:0]        den_reg, den_next;
    logic signed [16:0] do_reg, do_next;
    logic signed [34:0] prod_reg, prod_next;
    logic               qneg_reg, qneg_next;
    logic [15:0]        rem_reg, rem_next;
    logic [15:0]        dvd_reg, dvd_next;
    logic signed [15:0] res_reg, res_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]  m_tuser_reg, m_tuser_next;

    // Working values.
    logic               in_fire;
    logic               out_free;
    logic [CNT_W-1:0]   np_ext;
    logic [CNT_W-1:0]   np_clamped;
    logic [IDX_W-1:0]   last_idx;
    logic               seg_hit;
    logic [34:0]        prod_abs;
    logic [16:0]        div_shift;
    logic               div_ge;
    logic [17:0]        q_signed;
    logic [17:0]        sum_wide;
    logic [15:0]        out_val;
    logic               slot_ok;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign slot_ok       = (32'(in_slot) < MAX_POINTS);

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // Breakpoint count in use, held to the range the table supports.
    always_comb
    begin
        np_ext = CNT_W'(num_points_reg);
        if (np_ext < CNT_W'(2))
        begin
            np_clamped = CNT_W'(2);
        end
        else if (np_ext > CNT_W'(MAX_POINTS))
        begin
            np_clamped = CNT_W'(MAX_POINTS);
        end
        else
        begin
            np_clamped = np_ext;
        end
        last_idx = IDX_W'(np_clamped - CNT_W'(1));
    end

    // Table read address for the next cycle.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = '0;
            S_FIRST: rd_addr = last_reg;
            S_CHECK: rd_addr = IDX_W'(1);
            S_SCAN:  rd_addr = i_reg + IDX_W'(1);
            default: rd_addr = '0;
        endcase
    end

    // Segment test, product magnitude, divider step and final sum.
    assign seg_hit   = (mag_reg >= {1'b0, px_reg}) && (mag_reg <= {1'b0, rdata_reg.in});
    assign prod_abs  = prod_reg[34] ? 35'(35'd0 - prod_reg) : prod_reg;
    assign div_shift = {rem_reg, dvd_reg[15]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign q_signed  = qneg_reg ? 18'(18'd0 - {2'b00, dvd_reg}) : {2'b00, dvd_reg};
    assign sum_wide  = 18'({{2{po_reg[15]}}, po_reg} + q_signed);

    // Sign restore with saturation of the one value that overflows.
    always_comb
    begin
        if (neg_reg && (res_reg == 16'sh8000))
        begin
            out_val = 16'h7FFF;
        end
        else if (neg_reg)
        begin
            out_val = 16'(16'd0 - res_reg);
        end
        else
        begin
            out_val = res_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        num_points_next = num_points_reg;
        i_next          = i_reg;
        cnt_next        = cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        last_next       = last_reg;
        px_next         = px_reg;
        po_next         = po_reg;
        lo_next         = lo_reg;
        dx_next         = dx_reg;
        den_next        = den_reg;
        do_next         = do_reg;
        prod_next       = prod_reg;
        qneg_next       = qneg_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        res_next        = res_reg;
        stat_next       = stat_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (cfg_we)
        begin
            num_points_next = cfg_wdata;
        end

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == REQ_WRITE)
                    begin
                        neg_next   = 1'b0;
                        res_next   = '0;
                        stat_next  = STAT_WRITTEN;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        neg_next   = in_sample[15];
                        mag_next   = in_sample[15] ? 17'(17'd0 - {in_sample[15], in_sample})
                                                   : {1'b0, in_sample};
                        last_next  = last_idx;
                        state_next = S_FIRST;
                    end
                end
            end
            // First breakpoint arrives.
            S_FIRST:
            begin
                px_next    = rdata_reg.in;
                po_next    = rdata_reg.out;
                state_next = S_CHECK;
            end
            // Last breakpoint arrives: clamp or start the scan.
            S_CHECK:
            begin
                if (mag_reg < {1'b0, px_reg})
                begin
                    res_next   = po_reg;
                    stat_next  = STAT_LOW;
                    state_next = S_FIN;
                end
                else if (mag_reg >= {1'b0, rdata_reg.in})
                begin
                    res_next   = rdata_reg.out;
                    stat_next  = STAT_HIGH;
                    state_next = S_FIN;
                end
                else
                begin
                    lo_next    = rdata_reg.out;
                    i_next     = IDX_W'(1);
                    state_next = S_SCAN;
                end
            end
            // One segment per cycle: previous point in px/po, next one from the table.
            S_SCAN:
            begin
                if (seg_hit)
                begin
                    dx_next    = 17'(mag_reg - {1'b0, px_reg});
                    den_next   = 16'(rdata_reg.in - px_reg);
                    do_next    = 17'({rdata_reg.out[15], rdata_reg.out} - {po_reg[15], po_reg});
                    state_next = S_MUL;
                end
                else if (i_reg == last_reg)
                begin
                    res_next   = lo_reg;
                    stat_next  = STAT_HIGH;
                    state_next = S_FIN;
                end
                else
                begin
                    px_next = rdata_reg.in;
                    po_next = rdata_reg.out;
                    i_next  = i_reg + IDX_W'(1);
                end
            end
            S_MUL:
            begin
                prod_next = 35'($signed({1'b0, dx_reg}) * do_reg);
                if (den_reg == 16'd0)
                begin
                    res_next   = po_reg;
                    stat_next  = STAT_INTERP;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            // The quotient is below 2^16, so the top bits start as the remainder.
            S_NORM:
            begin
                qneg_next  = prod_reg[34];
                rem_next   = {1'b0, prod_abs[30:16]};
                dvd_next   = prod_abs[15:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            // Restoring division, one quotient bit per cycle.
            S_DIV:
            begin
                rem_next = div_ge ? 16'(div_shift - {1'b0, den_reg}) : div_shift[15:0];
                dvd_next = {dvd_reg[14:0], div_ge};
                cnt_next = cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                res_next   = sum_wide[15:0];
                stat_next  = STAT_INTERP;
                state_next = S_FIN;
            end
            // Hand the word to the output register once it is free.
            S_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = out_val;
                    m_tuser_next  = stat_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_points_reg <= NP_RESET;
            i_reg          <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_points_reg <= num_points_next;
            i_reg          <= i_next;
            cnt_reg        <= cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        last_reg    <= last_next;
        px_reg      <= px_next;
        po_reg      <= po_next;
        lo_reg      <= lo_next;
        dx_reg      <= dx_next;
        den_reg     <= den_next;
        do_reg      <= do_next;
        prod_reg    <= prod_next;
        qneg_reg    <= qneg_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        res_reg     <= res_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Breakpoint table: written only when a write word is taken, which is never
    // during a scan, so reads and writes do not collide.
    always_ff @(posedge clk)
    begin
        if (in_fire && (s_axis_tuser == REQ_WRITE) && slot_ok)
        begin
            knot_mem[IDX_W'(in_slot)] <= '{out: in_point_out, in: in_point_in};
        end
        rdata_reg <= knot_mem[rd_addr];
    end

endmodule

// ----- rtl/core/plcm_checker.sv -----
`timescale 1ns / 1ps

module plcm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [plcm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [plcm_pkg::STAT_W-1:0]       m_axis_tuser
);

    import plcm_pkg::*;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a take");

    // Results leave only from the finishing step, never while idle.
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

    // A breakpoint write answers with zero.
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_WRITTEN) |-> (m_axis_tdata == '0))
        else $error("write result carries a nonzero value");

endmodule

bind piecewise_linear_curve_map plcm_checker u_plcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/piecewise_linear_curve_map_tb.sv -----
`timescale 1ns / 1ps

module piecewise_linear_curve_map_tb;

    import plcm_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_POINTS;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 138;

    typedef struct packed {
        logic [15:0]       mapped;
        logic [STAT_W-1:0] status;
    } curve_word_t;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        req;
        logic [15:0] smp;
        logic [3:0]  slot;
        logic [15:0] pin;
        logic [15:0] pout;
        logic [4:0]  cfg;
        logic        typed;
        curve_word_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [NP_W-1:0]       cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: sample[15:0], point_index[19:16], point_in[35:20], point_out[51:36]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: req_type[0]
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: mapped[15:0]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: status[1:0]
    logic [STAT_W-1:0]     m_axis_tuser;

    // Shadow copy of the breakpoint table and the point count.
    int          knot_x [TABLE_DEPTH];
    int          knot_y [TABLE_DEPTH];
    logic [4:0]  curve_points = NP_RESET;

    curve_word_t curve_out_q [$];
    stim_row_t   dir_rows [$];

    int send_idle = 0;
    int recv_stall = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int n_interp = 0;
    int n_clamped = 0;
    int n_written = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    piecewise_linear_curve_map dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Number of breakpoints actually in use after clamping the register.
    function automatic int points_in_use();
        int n;
        n = curve_points;
        if (n < 2)
            n = 2;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Expected output word for one accepted input word. Breakpoint writes
    // update the shadow table here.
    function automatic curve_word_t shape_word(logic req, logic [15:0] smp, logic [3:0] slot,
                                               logic [15:0] pin, logic [15:0] pout);
        curve_word_t r;
        int          s;
        int          m;
        int          n;
        int          val;
        bit          neg;
        bit          hit;
        longint      num;
        longint      den;
        r = '0;
        if (req == REQ_WRITE)
        begin
            knot_x[slot] = int'(pin);
            knot_y[slot] = int'($signed(pout));
            r.status = STAT_WRITTEN;
            return r;
        end
        s = int'($signed(smp));
        neg = (s < 0);
        m = neg ? -s : s;
        n = points_in_use();
        if (m < knot_x[0])
        begin
            val = knot_y[0];
            r.status = STAT_LOW;
        end
        else if (m >= knot_x[n-1])
        begin
            val = knot_y[n-1];
            r.status = STAT_HIGH;
        end
        else
        begin
            // A table that is not ascending may leave no segment around m.
            val = knot_y[n-1];
            r.status = STAT_HIGH;
            hit = 1'b0;
            for (int i = 0; i + 1 < n && !hit; i++)
            begin
                if (m >= knot_x[i] && m <= knot_x[i+1])
                begin
                    hit = 1'b1;
                    r.status = STAT_INTERP;
                    den = longint'(knot_x[i+1]) - longint'(knot_x[i]);
                    if (den == 0)
                        val = knot_y[i];
                    else
                    begin
                        num = longint'(m - knot_x[i]) * longint'(knot_y[i+1] - knot_y[i]);
                        val = knot_y[i] + int'(num / den);
                    end
                end
            end
        end
        // Odd symmetry: negative samples give the negated value, saturated.
        if (neg)
        begin
            val = -val;
            if (val > 32767)
                val = 32767;
        end
        r.mapped = val[15:0];
        return r;
    endfunction

    function automatic stim_row_t row_write(int slot, int pin, int pout);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.req = REQ_WRITE;
        r.slot = slot[3:0];
        r.pin = pin[15:0];
        r.pout = pout[15:0];
        r.typed = 1'b1;
        r.want.status = STAT_WRITTEN;
        return r;
    endfunction

    function automatic stim_row_t row_map(int smp);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.req = REQ_MAP;
        r.smp = smp[15:0];
        return r;
    endfunction

    function automatic stim_row_t row_map_typed(int smp, int mapped, logic [STAT_W-1:0] st);
        stim_row_t r;
        r = row_map(smp);
        r.typed = 1'b1;
        r.want.mapped = mapped[15:0];
        r.want.status = st;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(int v);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg = v[4:0];
        return r;
    endfunction

    // Sample choice: mostly inside an active segment, some on breakpoints,
    // at the extremes, or anywhere at all.
    function automatic logic [15:0] pick_sample();
        int n;
        int i;
        int m;
        int sel;
        n = points_in_use();
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            m = $urandom;
            return m[15:0];
        end
        if (sel < 20)
        begin
            case ($urandom_range(0, 4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        if (sel < 32)
        begin
            i = $urandom_range(0, n - 1);
            m = knot_x[i] + int'($urandom_range(0, 2)) - 1;
            if (m < 0)
                m = 0;
            if (m > 32768)
                m = 32768;
        end
        else
        begin
            i = $urandom_range(0, n - 2);
            m = $urandom_range(knot_x[i], knot_x[i+1]);
        end
        if ($urandom_range(0, 1) == 1)
            m = -m;
        else if (m > 32767)
            m = 32767;
        return m[15:0];
    endfunction

    // Present one word, hold it until accepted, then record what it should give.
    task automatic drive_word(input logic req, input logic [15:0] smp, input logic [3:0] slot,
                              input logic [15:0] pin, input logic [15:0] pout,
                              input logic typed, input curve_word_t want);
        curve_word_t r;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {4'b0, pout, pin, slot, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = shape_word(req, smp, slot, pin, pout);
        if (typed)
            r = want;
        curve_out_q.push_back(r);
        words_in++;
        @(negedge clk);
    endtask

    // Let every outstanding word come back, then write the point count.
    task automatic set_points(input int v);
        s_axis_tvalid <= 1'b0;
        while (curve_out_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[NP_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        curve_points = v[4:0];
        n_settings++;
    endtask

    // The receiver stalls at random according to the current phase.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);

    // Compare each accepted output word with the oldest expectation.
    always @(posedge clk)
    begin
        curve_word_t exp_word;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (curve_out_q.size() == 0)
            begin
                $error("unexpected word: mapped %0d status %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_word = curve_out_q.pop_front();
                if (m_axis_tdata !== exp_word.mapped)
                begin
                    $error("mapped: expected %0d, got %0d",
                           $signed(exp_word.mapped), $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tuser !== exp_word.status)
                begin
                    $error("status: expected %0d, got %0d", exp_word.status, m_axis_tuser);
                    errors++;
                end
                case (exp_word.status)
                    STAT_INTERP: n_interp++;
                    STAT_WRITTEN: n_written++;
                    default: n_clamped++;
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("piecewise_linear_curve_map: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          phase_np [RAND_PHASES];
        int          n_eff;
        int          x;
        int          step_max;
        int          tmode;
        int          pin;
        int          rnd;
        logic [15:0] smp;

        phase_np = '{16, 2, 31, 0, 17, 1, 2, 16};
        phase_np[6] = $urandom_range(2, 16);
        phase_np[7] = $urandom_range(0, 31);

        // The table starts with two points, then tries zero-width and
        // descending segments and out-of-range point counts.
        dir_rows = '{
            row_write(0, 1000, 500),
            row_write(1, 32768, 32767),
            row_map_typed(0, 500, STAT_LOW),
            row_map_typed(-32768, -32767, STAT_HIGH),
            row_map(32767),
            row_map_typed(-999, -500, STAT_LOW),
            row_map_typed(1000, 500, STAT_INTERP),
            row_map(-20000),
            row_write(0, 0, -32768),
            row_map(-1),
            row_write(1, 16, -32768),
            row_map_typed(-100, 32767, STAT_HIGH),
            row_map(8),
            row_cfg(3),
            row_write(0, 50, 10),
            row_write(1, 50, 20),
            row_write(2, 300, 1000),
            row_map_typed(50, 10, STAT_INTERP),
            row_map_typed(-49, -10, STAT_LOW),
            row_map(175),
            row_write(2, 40, -7),
            row_map(60),
            row_cfg(0),
            row_map_typed(60, 20, STAT_HIGH),
            row_cfg(1),
            row_map_typed(-50, -20, STAT_HIGH)
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
                set_points(dir_rows[k].cfg);
            else
                drive_word(dir_rows[k].req, dir_rows[k].smp, dir_rows[k].slot,
                           dir_rows[k].pin, dir_rows[k].pout, dir_rows[k].typed,
                           dir_rows[k].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_points(phase_np[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            n_eff = points_in_use();

            // Reload the whole table: mostly ascending with random spacing,
            // sometimes in no order at all.
            tmode = $urandom_range(0, 5);
            x = (tmode == 5) ? 0 : int'($urandom_range(0, 400));
            case (tmode)
                1: step_max = 40;
                2: step_max = 2500;
                3: step_max = 65536 / n_eff;
                default: step_max = 32768 / n_eff + 1;
            endcase
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                if (tmode == 0)
                    pin = $urandom_range(0, 32768);
                else
                begin
                    pin = x;
                    if ($urandom_range(0, 7) != 0)
                        x += $urandom_range(1, step_max);
                    if (x > 32768)
                        x = 32768;
                end
                rnd = $urandom;
                drive_word(REQ_WRITE, rnd[31:16], k[3:0], pin[15:0], rnd[15:0], 1'b0, '0);
            end

            // Mostly mapped samples, now and then a single breakpoint rewrite.
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                rnd = $urandom;
                if ($urandom_range(0, 9) == 0)
                begin
                    x = $urandom_range(0, 15);
                    pin = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 32768))
                                                      : knot_x[x];
                    drive_word(REQ_WRITE, rnd[31:16], x[3:0], pin[15:0], rnd[15:0],
                               1'b0, '0);
                end
                else
                begin
                    smp = pick_sample();
                    pin = $urandom_range(0, 32768);
                    drive_word(REQ_MAP, smp, rnd[19:16], pin[15:0], rnd[15:0], 1'b0, '0);
                end
            end
        end

        // Drain and allow the slowest word time to appear.
        s_axis_tvalid <= 1'b0;
        while (curve_out_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (curve_out_q.size() != 0)
        begin
            $error("%0d expected words never arrived", curve_out_q.size());
            errors++;
        end

        $display("Sent %0d words over %0d point-count settings and 4 idling patterns.",
                 words_in, n_settings);
        $display("Received %0d: %0d interpolated, %0d clamped, %0d breakpoint writes.",
                 words_out, n_interp, n_clamped, n_written);
        if (errors == 0)
            $display("piecewise_linear_curve_map: match");
        else
            $display("piecewise_linear_curve_map: mismatch");
        $finish;
    end

endmodule
